FILE: rtl/core/mcib_pkg.sv
`timescale 1ns / 1ps

package mcib_pkg;

    localparam int unsigned PIX_W   = 8;
    localparam int unsigned PHASE_W = 9;
    localparam int unsigned MODE_W  = 3;
    localparam int unsigned INDEX_W = 2;
    localparam int unsigned DATA_W  = 9;
    // Products of an 8-bit pixel and a 9-bit weight, plus rounding
    localparam int unsigned PROD_W  = 17;

    localparam logic [PHASE_W-1:0] PHASE_FULL  = 9'd256;
    localparam logic [PHASE_W-1:0] PHASE_RESET = 9'd128;
    localparam logic [PIX_W-1:0]   PIX_MAX     = 8'd255;

    localparam logic [MODE_W-1:0] MODE_AVG     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_STATIC  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_DYNAMIC = 3'd2;
    localparam logic [MODE_W-1:0] MODE_MASK    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_OCCL    = 3'd4;
    localparam logic [MODE_W-1:0] MODE_PASS    = 3'd5;

    localparam logic [INDEX_W-1:0] REG_TIME_PHASE = 2'd0;
    localparam logic [INDEX_W-1:0] REG_BLEND_MODE = 2'd1;

    typedef struct packed {
        logic [PHASE_W-1:0] time_phase;
        logic [MODE_W-1:0]  blend_mode;
    } cfg_t;

    typedef struct packed {
        logic [PIX_W-1:0] comp_back;
        logic [PIX_W-1:0] comp_fwd;
        logic [PIX_W-1:0] prev_pixel;
        logic [PIX_W-1:0] next_pixel;
        logic [PIX_W-1:0] mask_back;
        logic [PIX_W-1:0] mask_fwd;
        logic [PIX_W-1:0] occlusion;
    } pix_in_t;

    typedef struct packed {
        logic [PIX_W-1:0] comp_avg;
        logic [PIX_W-1:0] temp_avg;
        logic [PIX_W-1:0] temp_avg_rnd;
        logic [PIX_W-1:0] bb;
        logic [PIX_W-1:0] ff;
        logic [PIX_W-1:0] prev_pixel;
        logic [PIX_W-1:0] next_pixel;
        logic [PIX_W-1:0] comp_back;
        logic [PIX_W-1:0] comp_fwd;
        logic [PIX_W-1:0] occlusion;
    } s1_t;

    typedef struct packed {
        logic [PIX_W-1:0] sel;
        logic [PIX_W-1:0] temp_avg_rnd;
        logic [PIX_W-1:0] mask_avg;
        logic [PIX_W-1:0] occlusion;
    } s2_t;

    // x*t + y*(256-t), t already saturated to 0..256
    function automatic logic [PROD_W-1:0] phase_sum(
        input logic [PIX_W-1:0]   x,
        input logic [PIX_W-1:0]   y,
        input logic [PHASE_W-1:0] t
    );
        logic [PHASE_W-1:0] u;
        u = PHASE_FULL - t;
        return PROD_W'({9'd0, x} * {8'd0, t}) + PROD_W'({9'd0, y} * {8'd0, u});
    endfunction

    // (w*x + (255-w)*y + 255) >> 8
    function automatic logic [PIX_W-1:0] mix_rnd(
        input logic [PIX_W-1:0] w,
        input logic [PIX_W-1:0] x,
        input logic [PIX_W-1:0] y
    );
        logic [PIX_W-1:0]  wn;
        logic [PROD_W-1:0] s;
        wn = PIX_MAX - w;
        s  = PROD_W'({9'd0, w} * {9'd0, x}) + PROD_W'({9'd0, wn} * {9'd0, y})
           + PROD_W'(PIX_MAX);
        return s[15:8];
    endfunction

endpackage

FILE: rtl/core/mc_interpolation_pixel_blend.sv
`timescale 1ns / 1ps

// Pixel blender for motion-compensated frame interpolation.
// Input channel: in_valid/in_ready with one pixel from each source
// (compensated backward/forward, previous/next, two masks, occlusion).
// Output channel: out_valid/out_ready with one blended out_pixel per item.
// Configuration: cfg_we/cfg_index/cfg_data write time_phase (index 0,
// saturated to 256) and blend_mode (index 1); other indexes are dropped.
// Write configuration only while no item is in flight.
// Structure: three register stages, the first loaded at the accepting edge,
// and the item leaves from the third. Throughput: one item per cycle while
// the receiver keeps out_ready high, through the three register
// stages (mask and phase products, mask phase blend with medians, occlusion
// blend).
// Reset clears all stage valid bits and loads time_phase 128 and the
// static median mode. When the receiver holds out_ready low the output
// holds its item and the stages fill up behind it; in_ready falls only
// once all three stages hold an item, so nothing is lost or repeated.
module mc_interpolation_pixel_blend
    import mcib_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [INDEX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]  cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [PIX_W-1:0]   comp_back,
    input  logic [PIX_W-1:0]   comp_fwd,
    input  logic [PIX_W-1:0]   prev_pixel,
    input  logic [PIX_W-1:0]   next_pixel,
    input  logic [PIX_W-1:0]   mask_back,
    input  logic [PIX_W-1:0]   mask_fwd,
    input  logic [PIX_W-1:0]   occlusion,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [PIX_W-1:0]   out_pixel
);

    cfg_t    cfg;
    pix_in_t in_data;
    s1_t     s1_data;
    s2_t     s2_data;
    logic    s1_valid;
    logic    s1_ready;
    logic    s2_valid;
    logic    s2_ready;

    assign in_data.comp_back  = comp_back;
    assign in_data.comp_fwd   = comp_fwd;
    assign in_data.prev_pixel = prev_pixel;
    assign in_data.next_pixel = next_pixel;
    assign in_data.mask_back  = mask_back;
    assign in_data.mask_fwd   = mask_fwd;
    assign in_data.occlusion  = occlusion;

    mcib_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mcib_premix u_premix (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (s1_valid),
        .out_ready (s1_ready),
        .out_data  (s1_data)
    );

    mcib_phase u_phase (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_data   (s1_data),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_data  (s2_data)
    );

    mcib_occl u_occl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s2_valid),
        .in_ready  (s2_ready),
        .in_data   (s2_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_pixel (out_pixel)
    );

    // A draining output means no stage can block the input
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled while output drains");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> s1_valid)
        else $error("accepted item missing from first stage");

    assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid && !s2_ready |=> s2_valid && $stable(s2_data))
        else $error("second stage item changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid && !s1_ready |-> s2_valid && out_valid && !out_ready)
        else $error("first stage stalled with room downstream");

endmodule

FILE: rtl/core/mcib_cfg.sv
`timescale 1ns / 1ps

module mcib_cfg
    import mcib_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [INDEX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]  cfg_data,
    output cfg_t               cfg
);

    logic [PHASE_W-1:0] time_phase_reg;
    logic [PHASE_W-1:0] time_phase_next;
    logic [MODE_W-1:0]  blend_mode_reg;
    logic [MODE_W-1:0]  blend_mode_next;
    logic [PHASE_W-1:0] phase_sat;

    // Saturate the phase at full backward weight
    assign phase_sat = (cfg_data > DATA_W'(PHASE_FULL)) ? PHASE_FULL : cfg_data[PHASE_W-1:0];

    always_comb
    begin
        time_phase_next = time_phase_reg;
        blend_mode_next = blend_mode_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TIME_PHASE: time_phase_next = phase_sat;
                REG_BLEND_MODE: blend_mode_next = cfg_data[MODE_W-1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_phase_reg <= PHASE_RESET;
            blend_mode_reg <= MODE_STATIC;
        end
        else
        begin
            time_phase_reg <= time_phase_next;
            blend_mode_reg <= blend_mode_next;
        end
    end

    assign cfg.time_phase = time_phase_reg;
    assign cfg.blend_mode = blend_mode_reg;

endmodule

FILE: rtl/core/mcib_premix.sv
`timescale 1ns / 1ps

module mcib_premix
    import mcib_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    in_valid,
    output logic    in_ready,
    input  pix_in_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output s1_t     out_data
);

    logic              valid_reg;
    logic              valid_next;
    s1_t               data_reg;
    s1_t               data_next;
    logic [PROD_W-1:0] comp_sum;
    logic [PROD_W-1:0] temp_sum;
    logic [PROD_W-1:0] temp_sum_rnd;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        comp_sum     = phase_sum(in_data.comp_back, in_data.comp_fwd, cfg.time_phase);
        temp_sum     = phase_sum(in_data.prev_pixel, in_data.next_pixel, cfg.time_phase);
        temp_sum_rnd = temp_sum + PROD_W'(PIX_MAX);

        data_next.comp_avg     = comp_sum[15:8];
        data_next.temp_avg     = temp_sum[15:8];
        data_next.temp_avg_rnd = temp_sum_rnd[15:8];
        data_next.bb           = mix_rnd(in_data.mask_back, in_data.comp_fwd, in_data.comp_back);
        data_next.ff           = mix_rnd(in_data.mask_fwd, in_data.comp_back, in_data.comp_fwd);
        data_next.prev_pixel   = in_data.prev_pixel;
        data_next.next_pixel   = in_data.next_pixel;
        data_next.comp_back    = in_data.comp_back;
        data_next.comp_fwd     = in_data.comp_fwd;
        data_next.occlusion    = in_data.occlusion;

        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Load payload only when an item is taken
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: rtl/core/mcib_phase.sv
`timescale 1ns / 1ps

module mcib_phase
    import mcib_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  logic in_valid,
    output logic in_ready,
    input  s1_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output s2_t  out_data
);

    logic              valid_reg;
    logic              valid_next;
    s2_t               data_reg;
    s2_t               data_next;
    logic [PROD_W-1:0] mask_sum;
    logic [PIX_W-1:0]  med_static;
    logic [PIX_W-1:0]  med_dynamic;

    function automatic logic [PIX_W-1:0] med3(
        input logic [PIX_W-1:0] a,
        input logic [PIX_W-1:0] b,
        input logic [PIX_W-1:0] c
    );
        logic [PIX_W-1:0] lo;
        logic [PIX_W-1:0] hi;
        logic [PIX_W-1:0] m;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        m  = (hi < c) ? hi : c;
        return (lo > m) ? lo : m;
    endfunction

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        mask_sum    = phase_sum(in_data.bb, in_data.ff, cfg.time_phase);
        med_static  = med3(in_data.prev_pixel, in_data.next_pixel, in_data.comp_avg);
        med_dynamic = med3(in_data.temp_avg, in_data.comp_back, in_data.comp_fwd);

        data_next.temp_avg_rnd = in_data.temp_avg_rnd;
        data_next.mask_avg     = mask_sum[15:8];
        data_next.occlusion    = in_data.occlusion;

        // Occlusion blend finishes in the next stage; sel is unused there
        unique case (cfg.blend_mode)
            MODE_AVG:     data_next.sel = in_data.comp_avg;
            MODE_STATIC:  data_next.sel = med_static;
            MODE_DYNAMIC: data_next.sel = med_dynamic;
            MODE_MASK:    data_next.sel = mask_sum[15:8];
            MODE_PASS:    data_next.sel = in_data.occlusion;
            default:      data_next.sel = '0;
        endcase

        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: rtl/core/mcib_occl.sv
`timescale 1ns / 1ps

module mcib_occl
    import mcib_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    input  logic             in_valid,
    output logic             in_ready,
    input  s2_t              in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [PIX_W-1:0] out_pixel
);

    logic             valid_reg;
    logic             valid_next;
    logic [PIX_W-1:0] pixel_reg;
    logic [PIX_W-1:0] pixel_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        if (cfg.blend_mode == MODE_OCCL)
        begin
            pixel_next = mix_rnd(in_data.occlusion, in_data.temp_avg_rnd, in_data.mask_avg);
        end
        else
        begin
            pixel_next = in_data.sel;
        end

        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            pixel_reg <= pixel_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_pixel = pixel_reg;

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import mcib_pkg::*;

    localparam logic [INDEX_W-1:0] REG_SPARE_LO  = 2'd2;
    localparam logic [INDEX_W-1:0] REG_SPARE_HI  = 2'd3;
    localparam int unsigned        HOLD_CYCLES   = 160;

    typedef struct {
        logic [PIX_W-1:0] pixel;
        int unsigned      seq;
    } blend_exp_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [INDEX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0]  cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [PIX_W-1:0]   comp_back = '0;
    logic [PIX_W-1:0]   comp_fwd = '0;
    logic [PIX_W-1:0]   prev_pixel = '0;
    logic [PIX_W-1:0]   next_pixel = '0;
    logic [PIX_W-1:0]   mask_back = '0;
    logic [PIX_W-1:0]   mask_fwd = '0;
    logic [PIX_W-1:0]   occlusion = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [PIX_W-1:0]   out_pixel;

    // Local copy of the blender registers
    logic [PHASE_W-1:0] cur_phase = PHASE_RESET;
    logic [MODE_W-1:0]  cur_mode = MODE_STATIC;

    pix_in_t     pixel_src_q[$];
    blend_exp_t  pixel_exp_q[$];
    pix_in_t     tx_next;
    pix_in_t     tx_cur = '0;
    blend_exp_t  rx_exp;
    int unsigned tx_wait = 0;
    int unsigned rx_stall = 0;
    int unsigned rx_hold = 0;
    bit          tx_calm = 1'b0;
    bit          rx_calm = 1'b0;
    int unsigned pixels_sent = 0;
    int unsigned pixels_seen = 0;
    int unsigned mismatches = 0;

    mc_interpolation_pixel_blend dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .comp_back  (comp_back),
        .comp_fwd   (comp_fwd),
        .prev_pixel (prev_pixel),
        .next_pixel (next_pixel),
        .mask_back  (mask_back),
        .mask_fwd   (mask_fwd),
        .occlusion  (occlusion),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_pixel  (out_pixel)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        #(20_000_000);
        $display("tb_top: errors");
        $finish;
    end

    function automatic int unsigned median3(int unsigned a, int unsigned b, int unsigned c);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        lo  = (a < b) ? a : b;
        hi  = (a < b) ? b : a;
        mid = (hi < c) ? hi : c;
        return (lo > mid) ? lo : mid;
    endfunction

    // (w*x + (255-w)*y + 255) / 256
    function automatic int unsigned weigh_rnd(int unsigned w, int unsigned x, int unsigned y);
        return (w * x + (255 - w) * y + 255) >> 8;
    endfunction

    function automatic int unsigned phase_blend(int unsigned x, int unsigned y,
                                                int unsigned t, int unsigned rnd);
        return (x * t + y * (256 - t) + rnd) >> 8;
    endfunction

    function automatic logic [PIX_W-1:0] blend_pixel(pix_in_t p, logic [PHASE_W-1:0] phase,
                                                     logic [MODE_W-1:0] mode);
        int unsigned t;
        int unsigned bb;
        int unsigned ff;
        int unsigned tavg;
        int unsigned r;
        // saturate: anything past 256 means backward side only
        t  = (phase > PHASE_FULL) ? 256 : int'(phase);
        bb = weigh_rnd(p.mask_back, p.comp_fwd, p.comp_back);
        ff = weigh_rnd(p.mask_fwd, p.comp_back, p.comp_fwd);
        case (mode)
            MODE_AVG:     r = phase_blend(p.comp_back, p.comp_fwd, t, 0);
            MODE_STATIC:  r = median3(p.prev_pixel, p.next_pixel,
                                      phase_blend(p.comp_back, p.comp_fwd, t, 0));
            MODE_DYNAMIC: r = median3(phase_blend(p.prev_pixel, p.next_pixel, t, 0),
                                      p.comp_back, p.comp_fwd);
            MODE_MASK:    r = phase_blend(bb, ff, t, 0);
            MODE_OCCL:
            begin
                tavg = phase_blend(p.prev_pixel, p.next_pixel, t, 255);
                r    = weigh_rnd(p.occlusion, tavg, phase_blend(bb, ff, t, 0));
            end
            MODE_PASS:    r = p.occlusion;
            default:      r = 0;
        endcase
        return PIX_W'(r);
    endfunction

    function automatic int unsigned draw_gap(bit calm);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 65)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic [PIX_W-1:0] rand_byte();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return PIX_MAX;
            default: return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic flag_mismatch(string msg);
        $display("tb_top: mismatch: %s", msg);
        mismatches++;
    endtask

    task automatic program_reg(logic [INDEX_W-1:0] idx, logic [DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_TIME_PHASE)
            cur_phase = data;
        else if (idx == REG_BLEND_MODE)
            cur_mode = data[MODE_W-1:0];
    endtask

    task automatic push_pixel(logic [PIX_W-1:0] b, logic [PIX_W-1:0] f, logic [PIX_W-1:0] p,
                              logic [PIX_W-1:0] n, logic [PIX_W-1:0] mb, logic [PIX_W-1:0] mf,
                              logic [PIX_W-1:0] o);
        pix_in_t item;
        item.comp_back  = b;
        item.comp_fwd   = f;
        item.prev_pixel = p;
        item.next_pixel = n;
        item.mask_back  = mb;
        item.mask_fwd   = mf;
        item.occlusion  = o;
        pixel_src_q.push_back(item);
    endtask

    // Wait until every queued item has gone through and come back out;
    // look between edges so the sender and receiver updates have landed
    task automatic settle();
        int unsigned guard;
        guard = 0;
        do
        begin
            @(negedge clk);
            guard++;
        end
        while ((pixel_src_q.size() != 0 || in_valid || pixel_exp_q.size() != 0)
               && guard < 200000);
        repeat (8) @(posedge clk);
    endtask

    // Sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            tx_wait  <= 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (in_valid)
            begin
                pixel_exp_q.push_back('{blend_pixel(tx_cur, cur_phase, cur_mode), pixels_sent});
                pixels_sent <= pixels_sent + 1;
            end
            if (tx_wait != 0)
            begin
                in_valid <= 1'b0;
                tx_wait  <= tx_wait - 1;
            end
            else if (pixel_src_q.size() != 0)
            begin
                tx_next = pixel_src_q.pop_front();
                tx_cur     <= tx_next;
                comp_back  <= tx_next.comp_back;
                comp_fwd   <= tx_next.comp_fwd;
                prev_pixel <= tx_next.prev_pixel;
                next_pixel <= tx_next.next_pixel;
                mask_back  <= tx_next.mask_back;
                mask_fwd   <= tx_next.mask_fwd;
                occlusion  <= tx_next.occlusion;
                in_valid   <= 1'b1;
                tx_wait    <= draw_gap(tx_calm);
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_stall  <= 0;
            rx_hold   <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                pixels_seen <= pixels_seen + 1;
                if (pixel_exp_q.size() == 0)
                begin
                    flag_mismatch($sformatf("out_pixel %0d with nothing pending", out_pixel));
                end
                else
                begin
                    rx_exp = pixel_exp_q.pop_front();
                    if (out_pixel !== rx_exp.pixel)
                        flag_mismatch($sformatf("item %0d out_pixel %0d, predicted %0d",
                                                rx_exp.seq, out_pixel, rx_exp.pixel));
                end
            end

            // long hold-off twice in the run so the pipeline backs up into in_ready
            if (rx_hold != 0)
            begin
                out_ready <= 1'b0;
                rx_hold   <= rx_hold - 1;
            end
            else if (out_valid && out_ready && (pixels_seen == 199 || pixels_seen == 799))
            begin
                out_ready <= 1'b0;
                rx_hold   <= HOLD_CYCLES;
            end
            else if (rx_stall != 0)
            begin
                out_ready <= 1'b0;
                rx_stall  <= rx_stall - 1;
            end
            else
            begin
                out_ready <= 1'b1;
                rx_stall  <= draw_gap(rx_calm);
            end
        end
    end

    initial
    begin
        logic [PHASE_W-1:0] dir_phase[8];
        logic [PHASE_W-1:0] extreme_phase[4];
        logic [MODE_W-1:0]  mode;
        logic [PHASE_W-1:0] phase;

        dir_phase     = '{9'd0, 9'd256, 9'd511, 9'd1, 9'd255, 9'd300, 9'd128, 9'd257};
        extreme_phase = '{9'd0, 9'd256, 9'd511, 9'd128};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values: phase 128, static median
        push_pixel(8'd200, 8'd10, 8'd90, 8'd120, 8'd0, 8'd0, 8'd0);
        settle();

        for (int k = 0; k < 8; k++)
        begin
            program_reg(REG_TIME_PHASE, dir_phase[k]);
            program_reg(REG_BLEND_MODE, DATA_W'(k));
            if (MODE_W'(k) == MODE_MASK)
            begin
                // spare indexes must leave both registers alone
                program_reg(REG_SPARE_LO, 9'h100);
                program_reg(REG_SPARE_HI, 9'h005);
            end
            push_pixel('0, '0, '0, '0, '0, '0, '0);
            push_pixel(PIX_MAX, PIX_MAX, PIX_MAX, PIX_MAX, PIX_MAX, PIX_MAX, PIX_MAX);
            push_pixel(PIX_MAX, '0, '0, PIX_MAX, PIX_MAX, '0, 8'd128);
            settle();
        end

        for (int k = 0; k < 12; k++)
        begin
            if (k < 8)
                mode = MODE_W'(k);
            else
                mode = MODE_W'($urandom_range(0, 5));
            if (k < 4)
                phase = extreme_phase[k];
            else if ($urandom_range(0, 3) == 0)
                phase = PHASE_W'($urandom_range(257, 511));
            else
                phase = PHASE_W'($urandom_range(0, 256));
            program_reg(REG_TIME_PHASE, phase);
            program_reg(REG_BLEND_MODE, DATA_W'(mode));
            tx_calm <= ($urandom_range(0, 3) == 0);
            rx_calm <= ($urandom_range(0, 3) == 0);
            for (int i = 0; i < 105; i++)
                push_pixel(rand_byte(), rand_byte(), rand_byte(), rand_byte(),
                           rand_byte(), rand_byte(), rand_byte());
            settle();
        end

        if (pixel_exp_q.size() != 0)
            flag_mismatch($sformatf("%0d predicted pixels never came out", pixel_exp_q.size()));

        $display("tb_top: %0d pixels sent, %0d checked, %0d mismatches", pixels_sent,
                 pixels_seen, mismatches);
        $display("tb_top: covered all eight mode codes, phases 0..511 and receiver hold-offs");
        if (mismatches == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
